### hw/rtl/amd_pkg.sv
// shared types, constants and helpers for the affine unmask pipeline
package amd_pkg;

   localparam int unsigned DATA_WIDTH       = 32;
   localparam int unsigned MOD_BITS_WIDTH   = 6;
   localparam int unsigned INVERSE_EXP_BITS = 31;
   localparam int unsigned CSR_ADDR_WIDTH   = 3;

   localparam logic [MOD_BITS_WIDTH-1:0] MOD_BITS_RESET   = 6'd32;
   localparam logic [DATA_WIDTH-1:0]     BIAS_SCALE_RESET = '0;

   // register byte addresses
   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_MOD_BITS   = 3'd0,
      CSR_BIAS_SCALE = 3'd4
   } csr_addr_type;

   typedef logic [DATA_WIDTH-1:0] word_type;

   // data carried from one exponent cell to the next
   typedef struct packed {
      logic     valid;
      word_type acc;
      word_type base;
      word_type diff;
      word_type mask;
   } cell_bus_type;

   // mask with the low k bits set, k saturated at the data width
   function automatic word_type mod_mask(input logic [MOD_BITS_WIDTH-1:0] k);
      logic [DATA_WIDTH:0] one_hot;
      one_hot = '0;
      if (k >= MOD_BITS_WIDTH'(DATA_WIDTH)) begin
         return '1;
      end
      one_hot[k] = 1'b1;
      return word_type'(one_hot - 1'b1);
   endfunction

endpackage

### hw/rtl/amd_mulmod.sv
// registered 32x32 multiply, low word masked to the modulus
module amd_mulmod
   import amd_pkg::*;
(
   input  logic     clock,
   input  word_type op_a,
   input  word_type op_b,
   input  word_type mask,
   output word_type prod
);

   word_type prod_ff;

   // low half product is all the modulus needs
   always_ff @(posedge clock) begin
      prod_ff <= word_type'(op_a * op_b) & mask;
   end

   assign prod = prod_ff;

endmodule

### hw/rtl/amd_exp_cell.sv
// one square-and-multiply step of the inverse exponent chain
module amd_exp_cell
   import amd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_bus_type cell_in,
   output cell_bus_type cell_out
);

   logic     sq_valid_ff;
   word_type sq_base_ff;
   word_type sq_diff_ff;
   word_type sq_mask_ff;
   word_type sq_acc;
   word_type mul_acc;
   logic     valid_ff;
   word_type base_ff;
   word_type diff_ff;
   word_type mask_ff;

   // square stage
   amd_mulmod u_square (
      .clock (clock),
      .op_a  (cell_in.acc),
      .op_b  (cell_in.acc),
      .mask  (cell_in.mask),
      .prod  (sq_acc)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff <= cell_in.valid;
      end
      sq_base_ff <= cell_in.base;
      sq_diff_ff <= cell_in.diff;
      sq_mask_ff <= cell_in.mask;
   end

   // multiply-by-base stage
   amd_mulmod u_mult (
      .clock (clock),
      .op_a  (sq_acc),
      .op_b  (sq_base_ff),
      .mask  (sq_mask_ff),
      .prod  (mul_acc)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= sq_valid_ff;
      end
      base_ff <= sq_base_ff;
      diff_ff <= sq_diff_ff;
      mask_ff <= sq_mask_ff;
   end

   assign cell_out.valid = valid_ff;
   assign cell_out.acc   = mul_acc;
   assign cell_out.base  = base_ff;
   assign cell_out.diff  = diff_ff;
   assign cell_out.mask  = mask_ff;

endmodule

### hw/rtl/affine_mask_decrypt_mod_pow2.sv
// affine unmask top level: csr port, correction pipeline, exponent cell chain
//
// Usage: write mod_bits (addr 0x0) and bias_scale (addr 0x4) over the csr
// APB port while idle. Pulse req_start with the seven request fields; a
// request is taken whenever req_start is high (req_busy is always low), so
// one request per cycle is sustained. Each result appears on
// rsp_plain_value for one cycle with rsp_valid high, in request order.
// Each request passes through the three correction stages (two registered multiply
// levels plus the subtract), then two registered multiplies in each
// of the 31 square-and-multiply cells of the inverse chain, then one final
// registered multiply by the difference.
// The cell count, and so the latency, follows INVERSE_EXP_BITS.
// Reset is synchronous: it clears all valid flags in flight and restores
// mod_bits to 32 and bias_scale to 0. The receiver cannot stall, so no
// backpressure exists and nothing is buffered.
module affine_mask_decrypt_mod_pow2
   import amd_pkg::*;
#(
   parameter int unsigned NUM_CELLS = INVERSE_EXP_BITS
)(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_start,
   output logic                      req_busy,
   input  logic [31:0]               req_masked_value,
   input  logic [31:0]               req_row_mult_key,
   input  logic [31:0]               req_row_add_key,
   input  logic [31:0]               req_col_mult_key,
   input  logic [31:0]               req_col_add_key,
   input  logic [31:0]               req_row_total,
   input  logic [31:0]               req_col_total,
   output logic                      rsp_valid,
   output logic [31:0]               rsp_plain_value,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   logic [MOD_BITS_WIDTH-1:0] mod_bits_ff;
   word_type                  bias_scale_ff;
   logic                      csr_write;
   word_type                  mask;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_bits_ff   <= MOD_BITS_RESET;
         bias_scale_ff <= BIAS_SCALE_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr)
            CSR_MOD_BITS:   mod_bits_ff   <= csr_pwdata[MOD_BITS_WIDTH-1:0];
            CSR_BIAS_SCALE: bias_scale_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr)
         CSR_MOD_BITS:   csr_prdata = 32'(mod_bits_ff);
         CSR_BIAS_SCALE: csr_prdata = bias_scale_ff;
         default:        csr_prdata = '0;
      endcase
   end

   assign mask     = mod_mask(mod_bits_ff);
   assign req_busy = 1'b0;

   // stage 1: key products
   logic     s1_valid_ff;
   word_type s1_a1b2_ff, s1_a2b1_ff, s1_b1b2_ff, s1_a1a2_ff;
   word_type s1_x_ff, s1_rs_ff, s1_cs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_start;
      end
      s1_a1b2_ff <= word_type'(req_row_mult_key * req_col_add_key) & mask;
      s1_a2b1_ff <= word_type'(req_col_mult_key * req_row_add_key) & mask;
      s1_b1b2_ff <= word_type'(req_row_add_key * req_col_add_key) & mask;
      s1_a1a2_ff <= word_type'(req_row_mult_key * req_col_mult_key) & mask;
      s1_x_ff    <= req_masked_value;
      s1_rs_ff   <= req_row_total;
      s1_cs_ff   <= req_col_total;
   end

   // stage 2: weighted terms of the correction
   logic     s2_valid_ff;
   word_type s2_t1_ff, s2_t2_ff, s2_t3_ff, s2_a1a2_ff, s2_x_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_t1_ff   <= word_type'(s1_a1b2_ff * s1_rs_ff) & mask;
      s2_t2_ff   <= word_type'(s1_a2b1_ff * s1_cs_ff) & mask;
      s2_t3_ff   <= word_type'(s1_b1b2_ff * bias_scale_ff) & mask;
      s2_a1a2_ff <= s1_a1a2_ff;
      s2_x_ff    <= s1_x_ff;
   end

   // stage 3: subtract correction from masked value
   logic     s3_valid_ff;
   word_type s3_diff_ff, s3_a1a2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_diff_ff <= (s2_x_ff - s2_t1_ff - s2_t2_ff - s2_t3_ff) & mask;
      s3_a1a2_ff <= s2_a1a2_ff;
   end

   // exponent chain: acc starts at 1, each cell does acc = acc^2 * base
   cell_bus_type chain [NUM_CELLS+1];

   assign chain[0].valid = s3_valid_ff;
   assign chain[0].acc   = word_type'(1) & mask;
   assign chain[0].base  = s3_a1a2_ff;
   assign chain[0].diff  = s3_diff_ff;
   assign chain[0].mask  = mask;

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      amd_exp_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (chain[g]),
         .cell_out (chain[g+1])
      );
   end

   // final multiply by the inverse
   logic     out_valid_ff;
   word_type out_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= chain[NUM_CELLS].valid;
      end
      out_value_ff <= word_type'(chain[NUM_CELLS].diff * chain[NUM_CELLS].acc)
                      & chain[NUM_CELLS].mask;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_plain_value = out_value_ff;

`ifndef SYNTHESIS
   // a request shows up at the chain input after the s1, s2 and s3 registers
   a_req_to_chain: assert property (@(posedge clock) disable iff (reset)
      req_start |=> ##2 s3_valid_ff)
      else $error("request lost before exponent chain");

   // an even key product must unmask to zero
   a_even_zero: assert property (@(posedge clock) disable iff (reset)
      (chain[NUM_CELLS].valid && !chain[NUM_CELLS].base[0]) |=> (rsp_plain_value == '0))
      else $error("even key product gave a nonzero result");

   // result stays below the modulus
   a_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_plain_value & ~mask) == '0))
      else $error("result exceeds modulus");
`endif

endmodule

### test/amd_checker.sv
// checker for the affine unmask block: predicts each unmasked value and compares
`timescale 1ns / 100ps
module amd_checker
   import amd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_start,
   input  logic        req_busy,
   input  logic [31:0] req_masked_value,
   input  logic [31:0] req_row_mult_key,
   input  logic [31:0] req_row_add_key,
   input  logic [31:0] req_col_mult_key,
   input  logic [31:0] req_col_add_key,
   input  logic [31:0] req_row_total,
   input  logic [31:0] req_col_total,
   input  logic        rsp_valid,
   input  logic [31:0] rsp_plain_value,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          fail_count,
   output int          pending_count,
   output int          plain_count
);

   logic [5:0]  cfg_mod_bits;
   logic [31:0] cfg_bias_scale;
   logic [31:0] plain_queue[$];

   // low k bits set, k saturated at 32
   function automatic logic [63:0] low_mask(input logic [5:0] k);
      logic [6:0] kk;
      kk = (k > 6'd32) ? 7'd32 : {1'b0, k};
      return (64'd1 << kk) - 64'd1;
   endfunction

   // p^(2^31-1) mod 2^k by square then multiply
   function automatic logic [63:0] odd_inverse(input logic [63:0] p, input logic [63:0] m);
      logic [63:0] r;
      r = 64'd1 & m;
      p = p & m;
      for (int i = 0; i < INVERSE_EXP_BITS; i++) begin
         r = (r * r) & m;
         r = (r * p) & m;
      end
      return r;
   endfunction

   function automatic logic [31:0] unmask_value(input logic [31:0] x, input logic [31:0] a1,
         input logic [31:0] b1, input logic [31:0] a2, input logic [31:0] b2,
         input logic [31:0] rs, input logic [31:0] cs);
      logic [63:0] m, a1b2, a2b1, kb, corr, inv, diff;
      m    = low_mask(cfg_mod_bits);
      a1b2 = (64'(a1) * 64'(b2)) & m;
      a2b1 = (64'(a2) * 64'(b1)) & m;
      kb   = (((64'(b1) * 64'(b2)) & m) * 64'(cfg_bias_scale)) & m;
      corr = (((a1b2 * 64'(rs)) & m) + ((a2b1 * 64'(cs)) & m)) & m;
      corr = (corr + kb) & m;
      inv  = odd_inverse((64'(a1) * 64'(a2)) & m, m);
      diff = (64'(x) - corr) & m;
      return 32'((diff * inv) & m);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   assign pending_count = plain_queue.size();

   always @(posedge clock) begin
      if (reset) begin
         cfg_mod_bits   <= MOD_BITS_RESET;
         cfg_bias_scale <= BIAS_SCALE_RESET;
         plain_queue.delete();
      end else begin
         // register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == CSR_MOD_BITS) cfg_mod_bits <= csr_pwdata[5:0];
            else if (csr_paddr == CSR_BIAS_SCALE) cfg_bias_scale <= csr_pwdata;
         end
         // accepted request
         if (req_start && !req_busy)
            plain_queue.push_back(unmask_value(req_masked_value, req_row_mult_key,
               req_row_add_key, req_col_mult_key, req_col_add_key, req_row_total,
               req_col_total));
         // result compare
         if (rsp_valid) begin
            plain_count++;
            if (plain_queue.size() == 0) report_mismatch("result with nothing pending");
            else begin
               logic [31:0] want;
               want = plain_queue.pop_front();
               if (want !== rsp_plain_value)
                  report_mismatch($sformatf("plain_value got %h want %h", rsp_plain_value, want));
            end
         end
      end
   end

   initial begin
      fail_count = 0;
      plain_count = 0;
   end

endmodule

### test/tb_top.sv
// stimulus and verdict for the affine unmask block
`timescale 1ns / 100ps
module tb_top
   import amd_pkg::*;
();

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_start = 1'b0;
   logic        req_busy;
   logic [31:0] req_masked_value = '0, req_row_mult_key = '0, req_row_add_key = '0;
   logic [31:0] req_col_mult_key = '0, req_col_add_key = '0;
   logic [31:0] req_row_total = '0, req_col_total = '0;
   logic        rsp_valid;
   logic [31:0] rsp_plain_value;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count, pending_count, plain_count;
   int          request_count = 0;

   localparam int LATENCY = 66;

   always #4 clock = ~clock;

   affine_mask_decrypt_mod_pow2 u_dut (.*);

   amd_checker u_checker (.*);

   // apb write: setup phase, then access phase held until pready
   task automatic write_csr(input csr_addr_type addr, input logic [31:0] data);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= addr; csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   task automatic drain_requests();
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   // one request; start stays high across back-to-back requests
   task automatic send_request(input logic [31:0] x, a1, b1, a2, b2, rs, cs,
         input bit allow_gap);
      req_start <= 1'b1;
      req_masked_value <= x; req_row_mult_key <= a1; req_row_add_key <= b1;
      req_col_mult_key <= a2; req_col_add_key <= b2;
      req_row_total <= rs; req_col_total <= cs;
      do @(posedge clock); while (req_busy);
      request_count++;
      if (allow_gap && $urandom_range(0, 3) == 0) begin
         req_start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] rand_key(input bit odd);
      logic [31:0] v;
      case ($urandom_range(0, 4))
         0: v = '1;
         1: v = $urandom_range(0, 15);
         default: v = $urandom;
      endcase
      if (odd) v[0] = 1'b1;
      return v;
   endfunction

   task automatic random_phase(input int n, input bit allow_gap);
      for (int i = 0; i < n; i++) begin
         bit odd;
         odd = ($urandom_range(0, 9) != 0);
         send_request($urandom, rand_key(odd), rand_key(0), rand_key(odd), rand_key(0),
            rand_key(0), rand_key(0), allow_gap);
      end
      req_start <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [5:0] mod_list[6] = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd8, 6'd17};
      logic [31:0] bias_list[6] = '{32'd0, 32'hFFFF_FFFF, 32'd7, 32'h1234_5679,
         32'd1, $urandom};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset config, extremes, even and zero key products
      send_request('0, '0, '0, '0, '0, '0, '0, 0);
      send_request('1, '1, '1, '1, '1, '1, '1, 0);
      send_request(32'h1234_5678, 32'd1, '0, 32'd1, '0, '0, '0, 0);
      send_request('1, 32'd2, 32'd3, 32'd5, 32'd7, '1, '1, 0);
      send_request('1, '0, '1, '1, '1, '1, '1, 0);
      send_request(32'h8000_0000, 32'h8000_0001, 32'h8000_0000, 32'h7FFF_FFFF,
         32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 0);
      req_start <= 1'b0;
      @(posedge clock);
      drain_requests();

      // sweep register settings, each with random requests
      for (int p = 0; p < 6; p++) begin
         write_csr(CSR_MOD_BITS, 32'(mod_list[p]));
         write_csr(CSR_BIAS_SCALE, bias_list[p]);
         send_request('1, '1, '1, '1, '1, '1, '1, 0);
         send_request('0, 32'd3, '1, 32'd5, '1, '1, '1, 0);
         random_phase(55, 1);
         drain_requests();
      end
      // last stretch back to back
      write_csr(CSR_MOD_BITS, 32'd32);
      write_csr(CSR_BIAS_SCALE, $urandom);
      random_phase(40, 0);
      drain_requests();

      $display("%0d requests sent over 7 register settings including mod_bits 0, 1, 32 and 63",
         request_count);
      $display("%0d results checked, %0d mismatches", plain_count, fail_count);
      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout");
      $display("Some tests failed");
      $finish;
   end

endmodule

### affine_mask_decrypt_mod_pow2.f
hw/rtl/amd_pkg.sv
hw/rtl/amd_mulmod.sv
hw/rtl/amd_exp_cell.sv
hw/rtl/affine_mask_decrypt_mod_pow2.sv
test/amd_checker.sv
test/tb_top.sv
